// File: src/vad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_pkg: shared types and constants for the vector angle pipeline
// Widths, CORDIC angle table and the base-angle code used across stages.
// ----------------------------------------------------------------------------
package vad_pkg;

	localparam int ITERATIONS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int TABLE_LEN  = 24;
	localparam int ACC_FRAC   = 24;
	localparam int PRESCALE   = 40;

	localparam int STAGES  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	// magnitude grows by the CORDIC gain and sqrt(2); two guard bits cover it
	localparam int XY_W    = DIFF_W + PRESCALE + 2;
	localparam int Z_W     = 32;
	localparam int TOT_W   = Z_W + 3;
	localparam int ANGLE_W = 17;
	localparam int SHIFT   = ACC_FRAC - FRAC_BITS;

	localparam logic signed [TOT_W-1:0] BASE_ACC = TOT_W'(64'sd180 <<< ACC_FRAC);
	localparam logic signed [TOT_W-1:0] HALF     = TOT_W'(64'sd1 <<< (SHIFT - 1));
	localparam logic signed [TOT_W-1:0] LIMIT    = TOT_W'(64'sd180 <<< FRAC_BITS);

	typedef enum logic [1:0] {
		BASE_ZERO = 2'd0,
		BASE_POS  = 2'd1,
		BASE_NEG  = 2'd2
	} vad_base_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		vad_base_t              base;
	} vad_vec_t;

	// atan(2^-i) in degrees, scaled by 2^ACC_FRAC
	function automatic logic [Z_W-2:0] atan_tab(input int i);
		logic [Z_W-2:0] v;
		case (i)
			0:       v = 31'd754974720;
			1:       v = 31'd445687602;
			2:       v = 31'd235489088;
			3:       v = 31'd119537938;
			4:       v = 31'd60000934;
			5:       v = 31'd30029717;
			6:       v = 31'd15018523;
			7:       v = 31'd7509720;
			8:       v = 31'd3754917;
			9:       v = 31'd1877466;
			10:      v = 31'd938734;
			11:      v = 31'd469367;
			12:      v = 31'd234684;
			13:      v = 31'd117342;
			14:      v = 31'd58671;
			15:      v = 31'd29335;
			16:      v = 31'd14668;
			17:      v = 31'd7334;
			18:      v = 31'd3667;
			19:      v = 31'd1833;
			20:      v = 31'd917;
			21:      v = 31'd458;
			22:      v = 31'd229;
			23:      v = 31'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: src/vad_prerot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_prerot: difference vector and quadrant fold
// Stage 1 forms end minus start; stage 2 folds x to non-negative and scales.
// ----------------------------------------------------------------------------
module vad_prerot
	import vad_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic                      out_valid,
	output vad_vec_t                  out_vec
);

	logic                     valid_s1;
	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;
	logic                     valid_s2;
	vad_vec_t                 vec_s2;

	logic signed [DIFF_W-1:0] fx;
	logic signed [DIFF_W-1:0] fy;
	vad_base_t                fbase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(end_x) - DIFF_W'(start_x);
		dy_s1 <= DIFF_W'(end_y) - DIFF_W'(start_y);
	end

	// negative x: turn by 180 degrees and remember which way the base goes
	always_comb begin
		if (dx_s1[DIFF_W-1]) begin
			fx    = -dx_s1;
			fy    = -dy_s1;
			fbase = dy_s1[DIFF_W-1] ? BASE_NEG : BASE_POS;
		end else begin
			fx    = dx_s1;
			fy    = dy_s1;
			fbase = BASE_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		vec_s2.x    <= XY_W'(fx) <<< PRESCALE;
		vec_s2.y    <= XY_W'(fy) <<< PRESCALE;
		vec_s2.base <= fbase;
	end

	assign out_valid = valid_s2;
	assign out_vec   = vec_s2;

endmodule

// File: src/vad_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_cordic: pipelined CORDIC vectoring chain
// One micro-rotation per register stage; the angle sum travels with x and y.
// ----------------------------------------------------------------------------
module vad_cordic
	import vad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  vad_vec_t              in_vec,
	output logic                  out_valid,
	output vad_base_t             out_base,
	output logic signed [Z_W-1:0] out_z
);

	logic                  valid_s [1:STAGES];
	vad_vec_t              vec_s   [1:STAGES];
	logic signed [Z_W-1:0] z_s     [1:STAGES];

	// stage inputs: the incoming word for the first rotation, the prior stage after
	logic                  valid_d [0:STAGES-1];
	vad_vec_t              vec_d   [0:STAGES-1];
	logic signed [Z_W-1:0] z_d     [0:STAGES-1];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		logic signed [Z_W-1:0]  step;
		logic                   y_pos;
		logic                   y_neg;

		if (g == 0) begin : g_src
			assign valid_d[g] = in_valid;
			assign vec_d[g]   = in_vec;
			assign z_d[g]     = '0;
		end else begin : g_src
			assign valid_d[g] = valid_s[g];
			assign vec_d[g]   = vec_s[g];
			assign z_d[g]     = z_s[g];
		end

		assign xs    = $signed(vec_d[g].x) >>> g;
		assign ys    = $signed(vec_d[g].y) >>> g;
		assign step  = Z_W'(atan_tab(g));
		assign y_neg = vec_d[g].y[XY_W-1];
		assign y_pos = !y_neg && (|vec_d[g].y);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_d[g];
			end
		end

		// rotate toward y = 0; hold when y is already zero
		always_ff @(posedge clk) begin
			vec_s[g+1].base <= vec_d[g].base;
			if (y_pos) begin
				vec_s[g+1].x <= $signed(vec_d[g].x) + ys;
				vec_s[g+1].y <= $signed(vec_d[g].y) - xs;
				z_s[g+1]     <= z_d[g] + step;
			end else if (y_neg) begin
				vec_s[g+1].x <= $signed(vec_d[g].x) - ys;
				vec_s[g+1].y <= $signed(vec_d[g].y) + xs;
				z_s[g+1]     <= z_d[g] - step;
			end else begin
				vec_s[g+1].x <= vec_d[g].x;
				vec_s[g+1].y <= vec_d[g].y;
				z_s[g+1]     <= z_d[g];
			end
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_base  = vec_s[STAGES].base;
	assign out_z     = z_s[STAGES];

endmodule

// File: src/vad_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_round: base angle, rounding and saturation
// Adds the quadrant base, rounds half up to the output grid, clamps to 180.
// ----------------------------------------------------------------------------
module vad_round
	import vad_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  vad_base_t                 in_base,
	input  logic signed [Z_W-1:0]     in_z,
	output logic                      out_valid,
	output logic signed [ANGLE_W-1:0] out_angle
);

	logic                     valid_s1;
	logic signed [TOT_W-1:0]  total_s1;
	logic                     valid_s2;
	logic signed [ANGLE_W-1:0] angle_s2;

	logic signed [TOT_W-1:0] base_acc;
	logic signed [TOT_W-1:0] res;
	logic signed [TOT_W-1:0] sat;

	always_comb begin
		case (in_base)
			BASE_POS: base_acc = BASE_ACC;
			BASE_NEG: base_acc = -BASE_ACC;
			default:  base_acc = '0;
		endcase
	end

	always_comb begin
		res = total_s1 >>> SHIFT;
		if (res > LIMIT) begin
			sat = LIMIT;
		end else if (res < -LIMIT) begin
			sat = -LIMIT;
		end else begin
			sat = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		total_s1 <= base_acc + TOT_W'(in_z) + HALF;
		angle_s2 <= sat[ANGLE_W-1:0];
	end

	assign out_valid = valid_s2;
	assign out_angle = angle_s2;

endmodule

// File: src/vector_angle_degrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees: direction of (end - start) in degrees
// atan2(dy, dx) by a pipelined CORDIC vectoring unit with quadrant fold.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | start_x, start_y, end_x, end_y (s16 each)
//  result   | done (one cycle)   | angle_deg (s17, 8 fraction bits, degrees)
//
// A word is taken at every edge with start high; busy is always low, since
// every stage advances each cycle and nothing ever has to wait.
// Two registers form the difference and quadrant fold, one register per
// CORDIC micro-rotation follows, and two more round and clamp the result.
// Throughput is one word per cycle.
// Reset clears only the valid bits; payload registers settle on their own.
// The receiver cannot stall: done is a strobe and the word is gone next cycle.
//
module vector_angle_degrees
	import vad_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic                      done,
	output logic signed [ANGLE_W-1:0] angle_deg
);

	logic                  pre_valid;
	vad_vec_t              pre_vec;
	logic                  cor_valid;
	vad_base_t             cor_base;
	logic signed [Z_W-1:0] cor_z;

	// the pipeline never holds, so a new word is welcome on every cycle
	assign busy = 1'b0;

	// subtract the points, fold negative x into the right half plane
	vad_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (pre_valid),
		.out_vec   (pre_vec)
	);

	// drive y to zero, accumulating the rotation in 2^-24 degree units
	vad_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pre_valid),
		.in_vec    (pre_vec),
		.out_valid (cor_valid),
		.out_base  (cor_base),
		.out_z     (cor_z)
	);

	// add the +/-180 base, round to the output grid, clamp
	vad_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_base   (cor_base),
		.in_z      (cor_z),
		.out_valid (done),
		.out_angle (angle_deg)
	);

endmodule

// File: tb/sv/vad_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_angle_checker: scoreboard for the vector angle pipeline
// Watches the command and result channels, predicts each angle and compares.
// ----------------------------------------------------------------------------
module vad_angle_checker
	import vad_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic                      done,
	input  logic signed [ANGLE_W-1:0] angle_deg,
	output int                        fail_count,
	output int                        pending
);

	localparam int     ROT_STEPS   = 16;
	localparam int     Q_ACC       = 24;
	localparam int     Q_OUT       = 8;
	localparam int     PRE_SHIFT   = 40;
	localparam longint ANGLE_LIMIT = 64'sd180 <<< Q_OUT;
	localparam int     MAX_PRINTS  = 200;

	typedef struct {
		longint                dx;
		longint                dy;
		logic [ANGLE_W-1:0]    angle;
	} angle_word_t;

	angle_word_t angle_queue[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// atan(2^-k) in degrees, 24 fraction bits
	function automatic longint micro_angle(input int k);
		case (k)
			0:  return 754974720;
			1:  return 445687602;
			2:  return 235489088;
			3:  return 119537938;
			4:  return 60000934;
			5:  return 30029717;
			6:  return 15018523;
			7:  return 7509720;
			8:  return 3754917;
			9:  return 1877466;
			10: return 938734;
			11: return 469367;
			12: return 234684;
			13: return 117342;
			14: return 58671;
			15: return 29335;
			default: return 0;
		endcase
	endfunction

	function automatic logic [ANGLE_W-1:0] atan2_degrees_fixed(input longint dx,
			input longint dy);
		longint x, y, z, base, xs, ys, total, res;
		z    = 0;
		base = 0;
		if (dx == 0 && dy == 0)
			return '0;
		// fold the left half plane onto the right one
		if (dx < 0) begin
			x    = -dx;
			y    = -dy;
			base = (dy >= 0) ? 180 : -180;
		end else begin
			x = dx;
			y = dy;
		end
		x = x <<< PRE_SHIFT;
		y = y <<< PRE_SHIFT;
		for (int k = 0; k < ROT_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + micro_angle(k);
			end else if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - micro_angle(k);
			end
		end
		total = (base <<< Q_ACC) + z;
		res   = (total + (64'sd1 <<< (Q_ACC - Q_OUT - 1))) >>> (Q_ACC - Q_OUT);
		if (res > ANGLE_LIMIT)
			res = ANGLE_LIMIT;
		if (res < -ANGLE_LIMIT)
			res = -ANGLE_LIMIT;
		return res[ANGLE_W-1:0];
	endfunction

	// keep the log short on a badly broken build; every mismatch still counts
	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTS)
			$display("%0t ns: MISMATCH %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk) begin
		angle_word_t w, got;
		if (arst_n) begin
			if (start && !busy) begin
				w.dx    = longint'(end_x) - longint'(start_x);
				w.dy    = longint'(end_y) - longint'(start_y);
				w.angle = atan2_degrees_fixed(w.dx, w.dy);
				angle_queue.push_back(w);
			end
			if (done) begin
				if (angle_queue.size() == 0) begin
					report_mismatch($sformatf("angle %0d with no word outstanding",
						angle_deg));
				end else begin
					got = angle_queue.pop_front();
					if (angle_deg !== got.angle)
						report_mismatch($sformatf(
							"dx %0d dy %0d: angle_deg %0d, predicted %0d",
							got.dx, got.dy, angle_deg, $signed(got.angle)));
				end
			end
			pending <= angle_queue.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for vector_angle_degrees
// Directed corner vectors, then shaped random point pairs with random gaps;
// a side checker predicts every angle and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
	import vad_pkg::*;

	localparam int RANDOM_WORDS = 1900;
	localparam int DRAIN_CYCLES = 28;
	localparam int MAX_GAP      = 6;

	logic                      clk     = 1'b0;
	logic                      arst_n  = 1'b0;
	logic                      start   = 1'b0;
	logic signed [COORD_W-1:0] start_x = '0;
	logic signed [COORD_W-1:0] start_y = '0;
	logic signed [COORD_W-1:0] end_x   = '0;
	logic signed [COORD_W-1:0] end_y   = '0;
	logic                      busy;
	logic                      done;
	logic signed [ANGLE_W-1:0] angle_deg;
	int                        fail_count;
	int                        pending;

	// when set, the sender pushes words back to back
	bit no_gaps = 1'b0;

	vector_angle_degrees u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.done      (done),
		.angle_deg (angle_deg)
	);

	vad_angle_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.done       (done),
		.angle_deg  (angle_deg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("vector_angle_degrees regression: fail");
		$finish;
	end

	// clamp a coordinate into the signed 16-bit pixel range
	function automatic int pix(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int any_pix();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// drive one word at a falling edge and hold it until the block takes it;
	// start stays high afterwards so back-to-back words see no dip
	task automatic send_points(input int sx, input int sy, input int ex, input int ey);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		start_x <= sx[COORD_W-1:0];
		start_y <= sy[COORD_W-1:0];
		end_x   <= ex[COORD_W-1:0];
		end_y   <= ey[COORD_W-1:0];
		do
			@(posedge clk);
		while (busy);
	endtask

	// drop start and hold off until every predicted angle has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// one random pair, shaped so that short, axis and diagonal vectors show up
	task automatic send_random_pair();
		int sx, sy, dx, dy, m;
		sx = any_pix();
		sy = any_pix();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				send_points(sx, sy, any_pix(), any_pix());
				return;
			end
			4, 5: begin
				dx = int'($urandom_range(0, 16)) - 8;
				dy = int'($urandom_range(0, 16)) - 8;
			end
			6: begin
				// pure axis vector
				m = int'($urandom_range(1, 65535)) * ($urandom_range(0, 1) ? 1 : -1);
				if ($urandom_range(0, 1)) begin
					dx = m;
					dy = 0;
				end else begin
					dx = 0;
					dy = m;
				end
			end
			7: begin
				// exact diagonal in any quadrant
				m  = $urandom_range(1, 32767);
				dx = $urandom_range(0, 1) ? m : -m;
				dy = $urandom_range(0, 1) ? m : -m;
			end
			8: begin
				// hug the negative x axis, where the fold picks +180 or -180
				dx = -int'($urandom_range(1, 65535));
				dy = int'($urandom_range(0, 4)) - 2;
			end
			default: begin
				dx = int'($urandom_range(0, 600)) - 300;
				dy = int'($urandom_range(0, 600)) - 300;
			end
		endcase
		// keep the wanted difference by moving start when end would clip
		sx = pix(sx + dx) - dx;
		sy = pix(sy + dy) - dy;
		send_points(sx, sy, sx + dx, sy + dy);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero vector, also at the corner of the coordinate range
		send_points(0, 0, 0, 0);
		send_points(-32768, -32768, -32768, -32768);
		// negative x axis: +180, longest and shortest
		send_points(32767, 5, -32768, 5);
		send_points(0, 0, -1, 0);
		// positive x axis and the two y directions at full length
		send_points(0, 0, 1, 0);
		send_points(-32768, 0, 32767, 0);
		send_points(0, -32768, 0, 32767);
		send_points(0, 32767, 0, -32768);
		// full-length diagonals in all four quadrants
		send_points(-32768, -32768, 32767, 32767);
		send_points(32767, -32768, -32768, 32767);
		send_points(32767, 32767, -32768, -32768);
		send_points(-32768, 32767, 32767, -32768);
		// just off the negative x axis on both sides: clamp region near 180
		send_points(32767, 0, -32768, -1);
		send_points(32767, 0, -32768, 1);
		// unit steps along the diagonals and the y axis
		send_points(0, 0, -1, -1);
		send_points(0, 0, 1, -1);
		send_points(0, 0, -1, 1);
		send_points(0, 0, 0, -1);
		send_points(-1, -1, -1, 0);
		// nearly vertical, longest dy with unit dx
		send_points(0, -32768, 1, 32767);
		send_points(0, -32768, -1, 32767);
		send_points(0, 32767, -1, -32768);

		// sender stalls until the pipe is empty
		wait_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// alternate stretches of back-to-back words with gappy ones
			if (n % 64 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if (n % 500 == 499)
				wait_drained();
			send_random_pair();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("vector_angle_degrees regression: pass");
		else
			$display("vector_angle_degrees regression: fail");
		$finish;
	end

endmodule
